>>> sv/efp_pkg.sv
// shared types, constants and codes of the escape-time fractal pixel block
package efp_pkg;

    localparam int IN_FRAC        = 28;
    localparam int FRAC_BITS_DEF  = 28;
    localparam int ITER_WIDTH_DEF = 12;

    // integer bits of the internal fixed-point values, sign included
    localparam int INT_BITS = 12;

    // operand slice of the shared multiplier
    localparam int CHUNK_W = 17;

    localparam int POINT_W    = 32;
    localparam int JULIA_W    = 31;
    localparam int RADIUS_W   = 5;
    localparam int CNT_FIELD_W = 12;
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic            KIND_JULIA = 1'b0;
    localparam logic            KIND_MANDEL = 1'b1;
    localparam logic            KIND_RST   = KIND_MANDEL;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 5'd20;
    localparam int              MAX_ITER_RST = 150;

    // divider step counter and quotient sizes
    localparam int DIV_CNT_W   = 3;
    localparam int FRAC_QBITS  = 8;
    localparam logic [DIV_CNT_W-1:0] SEC_LAST  = 3'd2;
    localparam logic [DIV_CNT_W-1:0] FRAC_LAST = 3'd7;

    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hff;
    localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'h00;

    // hue sectors
    localparam logic [2:0] SEC_RED_GREEN  = 3'd0;
    localparam logic [2:0] SEC_GREEN_RED  = 3'd1;
    localparam logic [2:0] SEC_GREEN_BLUE = 3'd2;
    localparam logic [2:0] SEC_BLUE_GREEN = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KIND     = 3'd0,
        CFG_JULIA_RE = 3'd1,
        CFG_JULIA_IM = 3'd2,
        CFG_RADIUS   = 3'd3,
        CFG_MAX_ITER = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_CMP,
        ST_XY,
        ST_UPD,
        ST_DIV_SEC,
        ST_DIV_FRAC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 run;
        logic [DIV_CNT_W-1:0] last;
    } div_ctl_t;

    typedef struct packed {
        logic signed [POINT_W-1:0] point_re;
        logic signed [POINT_W-1:0] point_im;
    } point_t;

    typedef struct packed {
        logic [CNT_FIELD_W-1:0] iterations_left;
        logic                   inside_res;
        logic [CHAN_W-1:0]      red;
        logic [CHAN_W-1:0]      green;
        logic [CHAN_W-1:0]      blue;
    } pixel_t;

endpackage

>>> sv/efp_mul.sv
// shared magnitude multiplier, one operand slice per cycle while run is high, most significant slice first
module efp_mul
    import efp_pkg::*;
#(
    parameter int MAG_W = FRAC_BITS_DEF + INT_BITS - 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               run,
    input  logic [MAG_W-1:0]   a,
    input  logic [MAG_W-1:0]   b,
    output logic               done,
    output logic [2*MAG_W-1:0] product
);

    localparam int NCH    = (MAG_W + CHUNK_W - 1) / CHUNK_W;
    localparam int CH_TOT = NCH * CHUNK_W;
    localparam int ACC_W  = MAG_W + CH_TOT;
    localparam int PP_W   = MAG_W + CHUNK_W;
    localparam int CNT_W  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NCH - 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [CH_TOT-1:0] bsh_reg, bsh_next, bsrc;
    logic [ACC_W-1:0]  acc_reg, acc_next, acc_base;
    logic [CHUNK_W-1:0] chunk;
    logic [PP_W-1:0]   pp;
    logic              first;

    always_comb
    begin
        first    = (cnt_reg == '0);
        bsrc     = first ? CH_TOT'(b) : bsh_reg;
        chunk    = bsrc[CH_TOT-1 -: CHUNK_W];
        bsh_next = bsrc << CHUNK_W;
        pp       = PP_W'(a) * PP_W'(chunk);
        acc_base = first ? '0 : (acc_reg << CHUNK_W);
        acc_next = acc_base + ACC_W'(pp);
        done_next = run && (cnt_reg == LAST);
        cnt_next  = cnt_reg;
        if (run)
        begin
            cnt_next = (cnt_reg == LAST) ? '0 : cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            bsh_reg <= bsh_next;
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg[2*MAG_W-1:0];

endmodule

>>> sv/efp_div.sv
// restoring divider, one quotient bit per cycle while ctl.run is high, for the hue sector and fraction
module efp_div
    import efp_pkg::*;
#(
    parameter int DV_W = ITER_WIDTH_DEF + 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  div_ctl_t              ctl,
    input  logic [DV_W-1:0]       rem0,
    input  logic [FRAC_QBITS-1:0] lo0,
    input  logic [DV_W-1:0]       divisor,
    output logic                  done,
    output logic [FRAC_QBITS-1:0] quot,
    output logic [DV_W-1:0]       rem
);

    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [DV_W-1:0]       rem_reg, rem_next, rsrc;
    logic [FRAC_QBITS-1:0] lo_reg, lo_next, lsrc;
    logic [FRAC_QBITS-1:0] q_reg, q_next;
    logic [DV_W:0]         trial, diff;
    logic                  fits, first;

    always_comb
    begin
        first    = (cnt_reg == '0);
        rsrc     = first ? rem0 : rem_reg;
        lsrc     = first ? lo0 : lo_reg;
        trial    = {rsrc, lsrc[FRAC_QBITS-1]};
        fits     = (trial >= {1'b0, divisor});
        diff     = trial - {1'b0, divisor};
        rem_next = fits ? diff[DV_W-1:0] : trial[DV_W-1:0];
        lo_next  = lsrc << 1;
        q_next   = first ? {{(FRAC_QBITS-1){1'b0}}, fits} : {q_reg[FRAC_QBITS-2:0], fits};
        done_next = ctl.run && (cnt_reg == ctl.last);
        cnt_next  = cnt_reg;
        if (ctl.run)
        begin
            cnt_next = (cnt_reg == ctl.last) ? '0 : cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.run)
        begin
            rem_reg <= rem_next;
            lo_reg  <= lo_next;
            q_reg   <= q_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = rem_reg;

endmodule

>>> sv/escape_time_fractal_pixel.sv
// escape-time fractal pixel: iteration sequencer, datapath, colour and handshakes
//
//  channel   direction  handshake                 word
//  point     in         point_valid/point_stall   point_t (point_re, point_im, Q4.28)
//  pixel     out        pixel_valid/pixel_stall   pixel_t (iterations_left, inside_res, rgb)
//  config    in         cfg_we                    cfg_index, cfg_data
//
//  one point at a time; each product on the one shared multiplier is built from
//  n = ceil((FRAC_BITS+11)/17) operand slices; an iteration squares x and y, checks the
//  escape radius, then forms x*y and the update; on escape two divisions give the hue sector
//  and fraction; a zero budget skips the loop; point_stall stays high until the pixel
//  word is loaded; the block then takes the next point while that pixel waits on pixel_stall
//  rst_n clears the sequencer and the handshake state and sets the configuration registers to their defaults
module escape_time_fractal_pixel
    import efp_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ITER_WIDTH = ITER_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  point_valid,
    output logic                  point_stall,
    input  point_t                point,
    output logic                  pixel_valid,
    input  logic                  pixel_stall,
    output pixel_t                pixel,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int VAL_W  = FRAC_BITS + INT_BITS;
    localparam int MAG_W  = VAL_W - 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int HI_W   = SUM_W - 2 * FRAC_BITS;
    localparam int RSQ_W  = 2 * RADIUS_W;
    localparam int SHL    = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
    localparam int SHR    = (FRAC_BITS >= IN_FRAC) ? 0 : IN_FRAC - FRAC_BITS;
    localparam int AL_W   = (VAL_W > POINT_W + SHL) ? VAL_W : POINT_W + SHL;
    localparam int DV_W   = ITER_WIDTH + 1;
    localparam int NUM_W  = ITER_WIDTH + 9;
    localparam int MAXW   = (ITER_WIDTH < CNT_FIELD_W) ? ITER_WIDTH : CNT_FIELD_W;

    state_t state_reg, state_next;

    // configuration
    logic                       kind_reg;
    logic signed [JULIA_W-1:0]  julia_re_reg, julia_im_reg;
    logic [RADIUS_W-1:0]        radius_reg;
    logic [ITER_WIDTH-1:0]      max_iter_reg;

    // iteration datapath
    logic signed [VAL_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [VAL_W-1:0] cr_reg, cr_next, ci_reg, ci_next;
    logic signed [VAL_W-1:0] xx_reg, xx_next, yy_reg, yy_next, xy_reg, xy_next;
    logic [PROD_W-1:0]       x2_reg, x2_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [ITER_WIDTH-1:0]   left_reg, left_next;
    logic                    init_reg, init_next;
    logic [2:0]              sec_reg, sec_next;
    logic [ITER_WIDTH-1:0]   r_reg, r_next;
    logic [CHAN_W-1:0]       f_reg, f_next;
    logic                    exact_reg, exact_next;
    logic                    pixel_valid_reg, pixel_valid_next;
    pixel_t                  pixel_reg, pixel_next;

    logic signed [AL_W-1:0]  al_pre_re, al_pre_im, al_re, al_im;
    logic signed [AL_W-1:0]  al_pre_jre, al_pre_jim, al_jre, al_jim;
    logic signed [VAL_W-1:0] pt_re, pt_im, jc_re, jc_im;
    logic [MAG_W-1:0]        mag_x, mag_y;
    logic                    accept, out_free, out_load, escaped, xy_neg;
    logic [HI_W-1:0]         sum_hi;
    logic [RSQ_W-1:0]        rsq;
    logic [PROD_W+1:0]       xy_t;
    logic signed [VAL_W-1:0] xy_m;
    logic [NUM_W-1:0]        frac_num;
    logic [CHAN_W:0]         q_wide;
    logic [CHAN_W-1:0]       q_val;

    // shared units
    logic               mul_run, mul_done;
    logic [MAG_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]  mul_product;
    div_ctl_t           div_ctl;
    logic               div_done;
    logic [DV_W-1:0]    div_rem0, div_divisor, div_rem;
    logic [FRAC_QBITS-1:0] div_lo0, div_quot;

    efp_mul #(
        .MAG_W (MAG_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .run     (mul_run),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    efp_div #(
        .DV_W (DV_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (div_ctl),
        .rem0    (div_rem0),
        .lo0     (div_lo0),
        .divisor (div_divisor),
        .done    (div_done),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    // input alignment to the internal fraction width, rounding toward minus infinity
    always_comb
    begin
        al_pre_re  = AL_W'(point.point_re);
        al_pre_im  = AL_W'(point.point_im);
        al_pre_jre = AL_W'(julia_re_reg);
        al_pre_jim = AL_W'(julia_im_reg);
        al_re  = (al_pre_re <<< SHL) >>> SHR;
        al_im  = (al_pre_im <<< SHL) >>> SHR;
        al_jre = (al_pre_jre <<< SHL) >>> SHR;
        al_jim = (al_pre_jim <<< SHL) >>> SHR;
        pt_re  = VAL_W'(al_re);
        pt_im  = VAL_W'(al_im);
        jc_re  = VAL_W'(al_jre);
        jc_im  = VAL_W'(al_jim);
    end

    always_comb
    begin
        mag_x    = x_reg[VAL_W-1] ? MAG_W'(-x_reg) : MAG_W'(x_reg);
        mag_y    = y_reg[VAL_W-1] ? MAG_W'(-y_reg) : MAG_W'(y_reg);
        rsq      = RSQ_W'(radius_reg) * RSQ_W'(radius_reg);
        sum_hi   = sum_reg[SUM_W-1 -: HI_W];
        escaped  = (sum_hi > HI_W'(rsq))
                   || ((sum_hi == HI_W'(rsq)) && (|sum_reg[2*FRAC_BITS-1:0]));
        xy_neg   = x_reg[VAL_W-1] ^ y_reg[VAL_W-1];
        xy_t     = {1'b0, mul_product, 1'b0}
                   + (xy_neg ? {{(PROD_W+2-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}} : '0);
        xy_m     = xy_t[FRAC_BITS +: VAL_W];
        frac_num = (NUM_W'(r_reg) << 9) - (NUM_W'(r_reg) << 1) + NUM_W'(max_iter_reg);
        q_wide   = exact_reg ? ((CHAN_W+1)'(256) - (CHAN_W+1)'(f_reg))
                             : ((CHAN_W+1)'(255) - (CHAN_W+1)'(f_reg));
        q_val    = q_wide[CHAN_W-1:0];
        out_free = !pixel_valid_reg || !pixel_stall;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (point_valid)
                begin
                    state_next = (max_iter_reg == '0) ? ST_DONE : ST_SQX;
                end
            end
            ST_SQX:
            begin
                if (mul_done)
                begin
                    state_next = ST_SQY;
                end
            end
            ST_SQY:
            begin
                if (mul_done)
                begin
                    state_next = init_reg ? ST_XY : ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (escaped)
                begin
                    state_next = ST_DIV_SEC;
                end
                else if (left_reg == ITER_WIDTH'(1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_XY;
                end
            end
            ST_XY:
            begin
                if (mul_done)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                state_next = ST_SQX;
            end
            ST_DIV_SEC:
            begin
                if (div_done)
                begin
                    state_next = ST_DIV_FRAC;
                end
            end
            ST_DIV_FRAC:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        point_stall = 1'b1;
        mul_run     = 1'b0;
        mul_a       = mag_x;
        mul_b       = mag_y;
        div_ctl     = '{run: 1'b0, last: SEC_LAST};
        div_rem0    = DV_W'(left_reg >> 1);
        div_lo0     = {left_reg[0], {(FRAC_QBITS-1){1'b0}}};
        div_divisor = DV_W'(max_iter_reg);
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                point_stall = 1'b0;
            end
            ST_SQX:
            begin
                mul_run = !mul_done;
                mul_b   = mag_x;
            end
            ST_SQY:
            begin
                mul_run = !mul_done;
                mul_a   = mag_y;
            end
            ST_XY:
            begin
                mul_run = !mul_done;
            end
            ST_DIV_SEC:
            begin
                div_ctl = '{run: !div_done, last: SEC_LAST};
            end
            ST_DIV_FRAC:
            begin
                div_ctl     = '{run: !div_done, last: FRAC_LAST};
                div_rem0    = frac_num[NUM_W-1:FRAC_QBITS];
                div_lo0     = frac_num[FRAC_QBITS-1:0];
                div_divisor = {max_iter_reg, 1'b0};
            end
            ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                point_stall = 1'b1;
            end
        endcase
    end

    assign accept = point_valid && !point_stall;

    // datapath
    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        xx_next    = xx_reg;
        yy_next    = yy_reg;
        xy_next    = xy_reg;
        x2_next    = x2_reg;
        sum_next   = sum_reg;
        left_next  = left_reg;
        init_next  = init_reg;
        sec_next   = sec_reg;
        r_next     = r_reg;
        f_next     = f_reg;
        exact_next = exact_reg;
        pixel_next = pixel_reg;

        if (accept)
        begin
            left_next = max_iter_reg;
            init_next = 1'b1;
            if (kind_reg == KIND_MANDEL)
            begin
                x_next  = '0;
                y_next  = '0;
                cr_next = pt_re;
                ci_next = pt_im;
            end
            else
            begin
                x_next  = pt_re;
                y_next  = pt_im;
                cr_next = jc_re;
                ci_next = jc_im;
            end
        end

        if ((state_reg == ST_SQX) && mul_done)
        begin
            x2_next = mul_product;
            xx_next = mul_product[FRAC_BITS +: VAL_W];
        end

        if ((state_reg == ST_SQY) && mul_done)
        begin
            sum_next  = SUM_W'(x2_reg) + SUM_W'(mul_product);
            yy_next   = mul_product[FRAC_BITS +: VAL_W];
            init_next = 1'b0;
        end

        if ((state_reg == ST_CMP) && !escaped)
        begin
            left_next = left_reg - ITER_WIDTH'(1);
        end

        if ((state_reg == ST_XY) && mul_done)
        begin
            xy_next = xy_neg ? -xy_m : xy_m;
        end

        if (state_reg == ST_UPD)
        begin
            x_next = xx_reg - yy_reg + cr_reg;
            y_next = xy_reg + ci_reg;
        end

        if ((state_reg == ST_DIV_SEC) && div_done)
        begin
            sec_next = div_quot[2:0];
            r_next   = ITER_WIDTH'(div_rem);
        end

        if ((state_reg == ST_DIV_FRAC) && div_done)
        begin
            f_next     = div_quot;
            exact_next = (div_rem == '0);
        end

        if (out_load)
        begin
            pixel_next.iterations_left = CNT_FIELD_W'(left_reg);
            pixel_next.inside_res      = (left_reg == '0);
            pixel_next.red             = CHAN_ZERO;
            pixel_next.green           = CHAN_ZERO;
            pixel_next.blue            = CHAN_ZERO;
            if (left_reg != '0)
            begin
                case (sec_reg)
                    SEC_RED_GREEN:
                    begin
                        pixel_next.red   = CHAN_FULL;
                        pixel_next.green = f_reg;
                    end
                    SEC_GREEN_RED:
                    begin
                        pixel_next.red   = q_val;
                        pixel_next.green = CHAN_FULL;
                    end
                    SEC_GREEN_BLUE:
                    begin
                        pixel_next.green = CHAN_FULL;
                        pixel_next.blue  = f_reg;
                    end
                    SEC_BLUE_GREEN:
                    begin
                        pixel_next.green = q_val;
                        pixel_next.blue  = CHAN_FULL;
                    end
                    default:
                    begin
                        pixel_next.red  = f_reg;
                        pixel_next.blue = CHAN_FULL;
                    end
                endcase
            end
        end

        pixel_valid_next = pixel_valid_reg;
        if (out_load)
        begin
            pixel_valid_next = 1'b1;
        end
        else if (!pixel_stall)
        begin
            pixel_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pixel_valid_reg <= 1'b0;
            left_reg        <= '0;
            init_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pixel_valid_reg <= pixel_valid_next;
            left_reg        <= left_next;
            init_reg        <= init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        cr_reg    <= cr_next;
        ci_reg    <= ci_next;
        xx_reg    <= xx_next;
        yy_reg    <= yy_next;
        xy_reg    <= xy_next;
        x2_reg    <= x2_next;
        sum_reg   <= sum_next;
        sec_reg   <= sec_next;
        r_reg     <= r_next;
        f_reg     <= f_next;
        exact_reg <= exact_next;
        pixel_reg <= pixel_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= KIND_RST;
            julia_re_reg <= '0;
            julia_im_reg <= '0;
            radius_reg   <= RADIUS_RST;
            max_iter_reg <= ITER_WIDTH'(MAX_ITER_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KIND:     kind_reg     <= cfg_data[0];
                CFG_JULIA_RE: julia_re_reg <= cfg_data[JULIA_W-1:0];
                CFG_JULIA_IM: julia_im_reg <= cfg_data[JULIA_W-1:0];
                CFG_RADIUS:   radius_reg   <= cfg_data[RADIUS_W-1:0];
                CFG_MAX_ITER: max_iter_reg <= ITER_WIDTH'(cfg_data[MAXW-1:0]);
                default:      kind_reg     <= kind_reg;
            endcase
        end
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel       = pixel_reg;

endmodule

>>> sv/efp_chk.sv
// port checker for the escape-time fractal pixel block, bound to the top level
module efp_chk
    import efp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  point_valid,
    input logic                  point_stall,
    input point_t                point,
    input logic                  pixel_valid,
    input logic                  pixel_stall,
    input pixel_t                pixel,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // the block works on one point at a time, so the input side closes after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && !point_stall) |=> point_stall)
        else $error("point accepted while previous point still in progress");

    a_inside_flag: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> (pixel.inside_res == (pixel.iterations_left == '0)))
        else $error("inside flag disagrees with iteration count");

    a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel.inside_res)
            |-> (pixel.red == '0 && pixel.green == '0 && pixel.blue == '0))
        else $error("inside pixel not black");

    a_outside_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel.inside_res)
            |-> (pixel.red == CHAN_FULL || pixel.green == CHAN_FULL
                 || pixel.blue == CHAN_FULL))
        else $error("escaped pixel has no full channel");

    a_pixel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel_stall) |=> (pixel_valid && $stable(pixel)))
        else $error("stalled pixel word changed");

endmodule

bind escape_time_fractal_pixel efp_chk u_efp_chk (.*);
